>>> rtl/core/lcs_pkg.sv
package lcs_pkg;

    // Operation codes of the input channel
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SECOND = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // Second-string byte travelling along the chain
    typedef struct packed {
        logic       valid;
        logic [7:0] sym;
        logic       case_sens;
    } t_tok;

    // Fold A-Z to lower case unless comparing exactly
    function automatic logic [7:0] fold(input logic [7:0] c, input logic case_sens);
        if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/lcs_length_engine.sv
// LCS length engine: length of the longest common subsequence of two byte strings.
// Input channel (i_valid / o_stall): i_op 0 appends a first-string byte, i_op 1
// feeds a second-string byte, i_op 2 finishes the pair; i_op 3 is taken and ignored.
// Output channel (o_valid / i_stall): one result per finish, holding the length
// and the overflow and order-error flags.
// Each first-string byte sits in one cell of a chain of MAX_LEN cells. A
// second-string byte enters the chain in the cycle after its transfer and moves one
// cell per cycle, so append and second-string transfers are taken every cycle while
// no finish is pending. A finish waits for the last byte to leave the chain, then
// loads the result register and clears the pair; input is stalled from the finish
// transfer until that load, which also raises o_valid.
// A result waiting under i_stall does not block appends or second-string bytes;
// only the result of a following finish waits for it to go, input stalled meanwhile.
// i_cfg_wr_en writes case_sensitive (reset 1); it is sampled with each second-string byte.
// Reset (synchronous, active low) empties the strings, zeroes the column and
// drops any pending result.
module lcs_length_engine
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [0:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_match_length,
    output logic       o_overflow,
    output logic       o_order_error
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    t_state          r_state;
    t_state          n_state;
    logic            r_case_sens;
    logic [CW-1:0]   r_count;
    logic            r_second;
    logic            r_overflow;
    logic            r_order_err;
    logic [CW-1:0]   r_drain;
    logic [CW-1:0]   n_drain;
    t_tok            r_tok;
    logic            accept;
    logic            emit;
    logic            out_free;
    logic [EW-1:0]   len_ext;

    t_tok            tok   [MAX_LEN+1];
    logic [CW-1:0]   diag  [MAX_LEN+1];
    logic [CW-1:0]   left  [MAX_LEN+1];

    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_sens <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_case_sens <= i_cfg_wr_data[0];
        end
    end

    // Finish sequencer; input is never stalled while idle
    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        emit    = 1'b0;
        o_stall = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_op == OP_FINISH) begin
                    n_state = ST_DRAIN;
                    n_drain = CW'(MAX_LEN);
                end
            end
            ST_DRAIN: begin
                o_stall = 1'b1;
                if (r_drain != '0) begin
                    n_drain = r_drain - CW'(1);
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    // Pair bookkeeping: fill count and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit) begin
            r_count     <= '0;
            r_second    <= 1'b0;
            r_overflow  <= 1'b0;
            r_order_err <= 1'b0;
        end else if (accept) begin
            if (i_op == OP_APPEND) begin
                priority if (r_second) begin
                    r_order_err <= 1'b1;
                end else if (r_count >= CW'(MAX_LEN)) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_op == OP_SECOND) begin
                r_second <= 1'b1;
            end
        end
    end

    // Entry stage of the chain
    always_ff @(posedge i_clk) begin
        r_tok.sym       <= fold(i_symbol, r_case_sens);
        r_tok.case_sens <= r_case_sens;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= accept && (i_op == OP_SECOND);
        end
    end

    assign tok[0]  = r_tok;
    assign diag[0] = '0;
    assign left[0] = '0;

    // Chain of cells, one per first-string position
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        logic load;
        assign load = accept && (i_op == OP_APPEND) && !r_second && (r_count == CW'(g));

        lcs_cell #(
            .W (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (emit),
            .i_load  (load),
            .i_byte  (i_symbol),
            .i_tok   (tok[g]),
            .i_diag  (diag[g]),
            .i_left  (left[g]),
            .o_tok   (tok[g+1]),
            .o_diag  (diag[g+1]),
            .o_left  (left[g+1])
        );
    end

    // Last cell holds the running maximum, which equals the entry at the fill count
    assign len_ext = EW'(left[MAX_LEN]);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_match_length <= (len_ext > EW'(127)) ? 7'd127 : len_ext[6:0];
            o_overflow     <= r_overflow;
            o_order_error  <= r_order_err;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("fill count beyond chain length");

    a_no_entry_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !accept)
        else $error("transfer taken while draining");

    a_chain_empty_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_tok.valid && !tok[MAX_LEN].valid))
        else $error("result taken with bytes still in the chain");

    // The last cell's hand-over register settles to zero once the cleared column entry has passed into it
    a_cleared_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_count == '0 && !r_second) ##1 (left[MAX_LEN] == '0))
        else $error("pair not cleared after result");
`endif

endmodule

>>> rtl/core/lcs_cell.sv
module lcs_cell
    import lcs_pkg::*;
#(
    parameter int W = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_clear,
    input  logic         i_load,
    input  logic [7:0]   i_byte,
    input  t_tok         i_tok,
    input  logic [W-1:0] i_diag,
    input  logic [W-1:0] i_left,
    output t_tok         o_tok,
    output logic [W-1:0] o_diag,
    output logic [W-1:0] o_left
);

    logic         r_valid;
    logic [7:0]   r_byte;
    logic [W-1:0] r_col;
    logic [W-1:0] n_col;
    logic         match;

    // Match only against a stored byte; empty cells just carry the maximum on
    assign match = r_valid && (fold(r_byte, i_tok.case_sens) == i_tok.sym);

    always_comb begin
        n_col = r_col;
        if (i_tok.valid) begin
            if (match) begin
                n_col = i_diag + W'(1);
            end else begin
                n_col = (r_col > i_left) ? r_col : i_left;
            end
        end
    end

    // Stored first-string byte
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    // Column entry, occupancy and hand-over to the next cell
    always_ff @(posedge i_clk) begin
        o_tok.sym       <= i_tok.sym;
        o_tok.case_sens <= i_tok.case_sens;
        o_diag          <= r_col;
        o_left          <= n_col;
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_col       <= '0;
            o_tok.valid <= 1'b0;
        end else if (i_clear) begin
            r_valid     <= 1'b0;
            r_col       <= '0;
            o_tok.valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end
            r_col       <= n_col;
            o_tok.valid <= i_tok.valid;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import lcs_pkg::*;
();

    localparam int MAX_LEN = 64;
    // Cycles for a second-string byte to leave the chain, with margin
    localparam int DRAIN_CYCLES = MAX_LEN + 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 540;
    localparam int NUM_ROWS = 25;
    // The block takes op 3 and does nothing with it
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [6:0] len;
        logic       ovf;
        logic       oerr;
    } t_lcs_res;

    // Directed row: op, symbol, repeat count, typed flag, typed result
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] sym;
        logic [6:0] reps;
        logic       typed;
        t_lcs_res   want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [NUM_ROWS] = '{
        '{OP_FINISH,  8'h00, 7'd1,  1'b1, '{7'd0,  1'b0, 1'b0}}, // empty pair after reset
        '{OP_APPEND,  8'h00, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'h00, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'hFF, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_FINISH,  8'hFF, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'h41, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}}, // second string only
        '{OP_FINISH,  8'h00, 7'd1,  1'b1, '{7'd0,  1'b0, 1'b0}},
        '{OP_APPEND,  8'hFF, 7'd64, 1'b0, '{7'd0,  1'b0, 1'b0}}, // full first string
        '{OP_SECOND,  8'hFF, 7'd64, 1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_FINISH,  8'h00, 7'd1,  1'b1, '{7'd64, 1'b0, 1'b0}},
        '{OP_APPEND,  8'h80, 7'd65, 1'b0, '{7'd0,  1'b0, 1'b0}}, // one byte too many
        '{OP_SECOND,  8'h80, 7'd2,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_FINISH,  8'h00, 7'd1,  1'b1, '{7'd2,  1'b1, 1'b0}},
        '{OP_APPEND,  8'h41, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'h61, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_APPEND,  8'h61, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}}, // append after second
        '{OP_IGNORED, 8'h5A, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_FINISH,  8'h00, 7'd1,  1'b1, '{7'd0,  1'b0, 1'b1}},
        '{OP_APPEND,  8'h5A, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_APPEND,  8'h7A, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'h7A, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_SECOND,  8'h5A, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_FINISH,  8'h00, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}},
        '{OP_IGNORED, 8'h00, 7'd1,  1'b0, '{7'd0,  1'b0, 1'b0}}, // op 3 alone
        '{OP_FINISH,  8'hA5, 7'd1,  1'b1, '{7'd0,  1'b0, 1'b0}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [0:0] i_cfg_wr_data = 1'b1;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_op = OP_APPEND;
    logic [7:0] i_symbol = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [6:0] o_match_length;
    logic       o_overflow;
    logic       o_order_error;

    // Predictor state
    logic [7:0] str_a [MAX_LEN];
    int         col_len [MAX_LEN];
    int         a_count;
    bit         b_started;
    bit         ovf_flag;
    bit         ord_flag;
    logic       case_exact;

    t_lcs_res   lcs_results_q [$];
    t_lcs_res   want_res;

    int tx_gap_pct;
    int rx_stall_pct;
    int items_sent;
    int pairs_sent;
    int results_checked;
    int mismatches;
    int cycle_count;

    lcs_length_engine #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_match_length (o_match_length),
        .o_overflow     (o_overflow),
        .o_order_error  (o_order_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        if (!case_exact && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic void clear_pair_state();
        for (int i = 0; i < MAX_LEN; i++) begin
            col_len[i] = 0;
        end
        a_count = 0;
        b_started = 1'b0;
        ovf_flag = 1'b0;
        ord_flag = 1'b0;
    endfunction

    // Advance the predicted LCS state by one accepted transfer
    function automatic void lcs_advance(input logic [1:0] op, input logic [7:0] sym);
        int       diag;
        int       left;
        int       prev;
        int       nv;
        int       len;
        logic [7:0] c;
        t_lcs_res r;
        case (op)
            OP_APPEND: begin
                if (b_started) begin
                    ord_flag = 1'b1;
                end else if (a_count >= MAX_LEN) begin
                    ovf_flag = 1'b1;
                end else begin
                    str_a[a_count] = sym;
                    a_count++;
                end
            end
            OP_SECOND: begin
                b_started = 1'b1;
                diag = 0;
                left = 0;
                c = fold_letter(sym);
                for (int i = 0; i < a_count; i++) begin
                    prev = col_len[i];
                    if (fold_letter(str_a[i]) == c) nv = diag + 1;
                    else nv = (prev > left) ? prev : left;
                    col_len[i] = nv;
                    diag = prev;
                    left = nv;
                end
            end
            OP_FINISH: begin
                len = (a_count > 0) ? col_len[a_count - 1] : 0;
                if (len > 127) len = 127;
                r.len = 7'(len);
                r.ovf = ovf_flag;
                r.oerr = ord_flag;
                lcs_results_q.push_back(r);
                clear_pair_state();
            end
            default: ;
        endcase
    endfunction

    // One transfer on the input channel, with random sender gaps
    task automatic send(input logic [1:0] op, input logic [7:0] sym);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        lcs_advance(op, sym);
        if (op != OP_IGNORED) items_sent++;
        if (op == OP_FINISH) pairs_sent++;
    endtask

    // Register write once the chain has drained
    task automatic set_case(input logic v);
        i_valid <= 1'b0;
        while (lcs_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case_exact = v;
    endtask

    // Small alphabet with both cases so that matches are common
    function automatic logic [7:0] pick_symbol();
        int r;
        logic [7:0] edges [6];
        edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h5A, 8'h7A};
        r = $urandom_range(0, 99);
        if (r < 35) return 8'(8'h41 + $urandom_range(0, 3));
        if (r < 70) return 8'(8'h61 + $urandom_range(0, 3));
        if (r < 80) return edges[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // A pair of strings with random content; some pairs are spoilt
    task automatic rand_pair();
        int  kind;
        int  la;
        int  lb;
        int  spoil_at;
        bit  spoilt;
        kind = $urandom_range(0, 99);
        la = (kind < 5) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 6) : $urandom_range(0, 12);
        lb = (kind < 10) ? $urandom_range(0, MAX_LEN + 6) : $urandom_range(0, 12);
        spoilt = ($urandom_range(0, 99) < 15);
        spoil_at = $urandom_range(0, lb);
        for (int i = 0; i < la; i++) begin
            send(OP_APPEND, pick_symbol());
        end
        for (int i = 0; i <= lb; i++) begin
            if (spoilt && i == spoil_at) begin
                if ($urandom_range(0, 1) == 1) send(OP_APPEND, pick_symbol());
                else send(OP_IGNORED, 8'($urandom_range(0, 255)));
            end
            if (i < lb) send(OP_SECOND, pick_symbol());
        end
        send(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked <= results_checked + 1;
            if (lcs_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: len=%0d ovf=%0b oerr=%0b",
                             o_match_length, o_overflow, o_order_error);
                end
            end else begin
                want_res = lcs_results_q.pop_front();
                if (o_match_length !== want_res.len || o_overflow !== want_res.ovf ||
                        o_order_error !== want_res.oerr) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected len=%0d ovf=%0b oerr=%0b",
                                 results_checked, want_res.len, want_res.ovf,
                                 want_res.oerr);
                        $display("    got len=%0d ovf=%0b oerr=%0b",
                                 o_match_length, o_overflow, o_order_error);
                    end
                end
            end
        end
    end

    initial begin
        int phase_start;
        items_sent = 0;
        pairs_sent = 0;
        results_checked = 0;
        mismatches = 0;
        cycle_count = 0;
        tx_gap_pct = 17;
        rx_stall_pct = 66;
        case_exact = 1'b1;
        clear_pair_state();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; a typed expectation stands in for the predicted one
        set_case(1'b1);
        for (int n = 0; n < NUM_ROWS; n++) begin
            for (int k = 0; k < DIR_ROWS[n].reps; k++) begin
                send(DIR_ROWS[n].op, DIR_ROWS[n].sym);
            end
            if (DIR_ROWS[n].typed) lcs_results_q[$] = DIR_ROWS[n].want;
        end

        // Random phases: folding on, exact, folding on; idling shifts each phase
        for (int p = 0; p < 3; p++) begin
            set_case(p == 1);
            tx_gap_pct = (p == 0) ? 17 : (p == 1) ? 66 : 0;
            rx_stall_pct = (p == 0) ? 66 : (p == 1) ? 17 : 0;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) rand_pair();
        end

        i_valid <= 1'b0;
        while (lcs_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += lcs_results_q.size();

        $display("Sent %0d transfers in %0d pairs, %0d results checked", items_sent,
                 pairs_sent, results_checked);
        $display("Covered full and overflowing strings, order errors, op 3, folding on and off");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/lcs_length_engine.sv
tb/tb_top.sv
